// ----- hw/rtl/nea_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the neighbor exclusion arbiter.
package nea_pkg;

    localparam int SEAT_W        = 3;
    localparam int CFG_W         = 4;
    localparam int DEF_MAX_SEATS = 8;
    localparam int RING_MIN      = 2;
    localparam int RING_RESET    = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic OP_ACQUIRE   = 1'b0;
    localparam logic OP_RELEASE   = 1'b1;
    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_RECHECK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SEAT_W-1:0] seat;
        logic              bad;
    } t_job;

    typedef enum logic {
        BK_FIRST,
        BK_RIGHT
    } t_bk_state;

endpackage

// ----- hw/rtl/nea_front.sv -----
`timescale 1ns / 1ps
// Front end: ring size register, request intake and seat range check.
module nea_front import nea_pkg::*; #(
    parameter int MAX_SEATS = DEF_MAX_SEATS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_op,
    input  logic [SEAT_W-1:0]                i_seat,
    input  logic                             i_cfg_valid,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    output logic                             o_cfg_ready,
    input  logic                             i_q_full,
    output logic                             o_push,
    output t_job                             o_job,
    output logic [$clog2(MAX_SEATS+1)-1:0]   o_ring
);

    localparam int NW       = $clog2(MAX_SEATS + 1);
    localparam int RING_RST = (RING_RESET > MAX_SEATS) ? MAX_SEATS : RING_RESET;

    logic [NW-1:0] r_ring;
    logic [NW-1:0] n_ring;

    // ring size is kept clamped to the legal range
    always_comb begin
        n_ring = r_ring;
        if (i_cfg_valid) begin
            if (int'(i_cfg_data) < RING_MIN) begin
                n_ring = NW'(RING_MIN);
            end else if (int'(i_cfg_data) > MAX_SEATS) begin
                n_ring = NW'(MAX_SEATS);
            end else begin
                n_ring = NW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= NW'(RING_RST);
        end else begin
            r_ring <= n_ring;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ring      = r_ring;
    assign o_busy      = i_q_full;
    assign o_push      = i_start & ~i_q_full;
    assign o_job.op    = i_op;
    assign o_job.seat  = i_seat;
    assign o_job.bad   = int'(i_seat) >= int'(r_ring);

endmodule

// ----- hw/rtl/nea_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between front end and back end.
module nea_fifo import nea_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr;
    logic [QP_W-1:0]  r_rd;
    logic [CNT_W-1:0] r_count;
    logic [QP_W-1:0]  n_wr;
    logic [QP_W-1:0]  n_rd;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign do_pop  = i_pop & (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QP_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QP_W'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/nea_back.sv -----
`timescale 1ns / 1ps
// Back end: seat state cells, grant checks and result register.
module nea_back import nea_pkg::*; #(
    parameter int MAX_SEATS = DEF_MAX_SEATS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  t_job                           i_job,
    output logic                           o_pop,
    input  logic [$clog2(MAX_SEATS+1)-1:0] i_ring,
    output logic                           o_valid,
    output logic [SEAT_W-1:0]              o_target_seat,
    output logic                           o_granted,
    output logic                           o_kind,
    output logic                           o_bad_seat,
    output logic                           o_last
);

    // only seats reachable through the seat field hold state
    localparam int DEPTH = (MAX_SEATS < (1 << SEAT_W)) ? MAX_SEATS : (1 << SEAT_W);
    localparam int SW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_SEATS);
    localparam int NW    = $clog2(MAX_SEATS + 1);

    t_bk_state         r_state;
    t_bk_state         n_state;
    logic [DEPTH-1:0]  r_hun;
    logic [DEPTH-1:0]  r_eat;
    logic [DEPTH-1:0]  n_hun;
    logic [DEPTH-1:0]  n_eat;
    logic [DEPTH-1:0]  hun_m;
    logic [DEPTH-1:0]  eat_m;
    logic [DEPTH-1:0]  ok;
    logic [TW-1:0]     r_seat;
    logic [TW-1:0]     cur_seat;
    logic [TW-1:0]     left_t;
    logic [TW-1:0]     right_t;
    logic [TW-1:0]     tgt;
    logic [SW-1:0]     seat_ix;
    logic [SW-1:0]     tix;
    logic [NW-1:0]     ring_m1;
    logic              step;
    logic              in_store;
    logic              grant;

    logic              r_valid;
    logic [SEAT_W-1:0] r_target;
    logic              r_granted;
    logic              r_kind;
    logic              r_bad;
    logic              r_last;
    logic              n_valid;
    logic [SEAT_W-1:0] n_target;
    logic              n_granted;
    logic              n_kind;
    logic              n_bad;
    logic              n_last;

    assign cur_seat = (r_state == BK_RIGHT) ? r_seat : TW'(i_job.seat);
    assign seat_ix  = cur_seat[SW-1:0];
    assign ring_m1  = i_ring - NW'(1);
    assign left_t   = (cur_seat == '0) ? ring_m1[TW-1:0] : cur_seat - TW'(1);
    assign right_t  = ((NW'(cur_seat) + NW'(1)) == i_ring) ? '0 : cur_seat + TW'(1);

    // own seat update ahead of the check: hungry on acquire, thinking on release
    always_comb begin
        hun_m = r_hun;
        eat_m = r_eat;
        if (r_state == BK_FIRST && i_head_valid && !i_job.bad) begin
            hun_m[seat_ix] = (i_job.op == OP_ACQUIRE);
            eat_m[seat_ix] = 1'b0;
        end
    end

    // one cell per seat: may it start eating now
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic le;
        logic re;
        if (i == 0) begin : g_wrap
            assign le = (int'(ring_m1) < DEPTH) ? eat_m[ring_m1[SW-1:0]] : 1'b0;
        end else begin : g_left
            assign le = eat_m[i-1];
        end
        if (i + 1 < DEPTH) begin : g_right
            assign re = (i_ring == NW'(i + 1)) ? eat_m[0] : eat_m[i+1];
        end else begin : g_edge
            assign re = (i_ring == NW'(i + 1)) ? eat_m[0] : 1'b0;
        end
        assign ok[i] = hun_m[i] & ~le & ~re;
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        step      = 1'b0;
        tgt       = cur_seat;
        n_valid   = 1'b0;
        n_kind    = KIND_REPLY;
        n_bad     = 1'b0;
        n_last    = 1'b1;
        unique case (r_state)
            BK_FIRST: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_valid = 1'b1;
                    if (i_job.bad) begin
                        n_bad  = 1'b1;
                        n_kind = (i_job.op == OP_RELEASE) ? KIND_RECHECK : KIND_REPLY;
                    end else if (i_job.op == OP_ACQUIRE) begin
                        step = 1'b1;
                    end else begin
                        step    = 1'b1;
                        tgt     = left_t;
                        n_kind  = KIND_RECHECK;
                        n_last  = 1'b0;
                        n_state = BK_RIGHT;
                    end
                end
            end
            BK_RIGHT: begin
                n_valid = 1'b1;
                step    = 1'b1;
                tgt     = right_t;
                n_kind  = KIND_RECHECK;
                n_state = BK_FIRST;
            end
            default: begin
                n_state = BK_FIRST;
            end
        endcase

        // seats past the stored ones are always thinking
        in_store  = step && (int'(tgt) < DEPTH);
        tix       = tgt[SW-1:0];
        grant     = in_store && ok[tix];
        n_granted = in_store && (eat_m[tix] || ok[tix]);
        n_target  = n_bad ? i_job.seat : SEAT_W'(tgt);

        n_hun = hun_m;
        n_eat = eat_m;
        if (grant) begin
            n_hun[tix] = 1'b0;
            n_eat[tix] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FIRST;
            r_hun   <= '0;
            r_eat   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hun   <= n_hun;
            r_eat   <= n_eat;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seat <= TW'(i_job.seat);
        end
        r_target  <= n_target;
        r_granted <= n_granted;
        r_kind    <= n_kind;
        r_bad     <= n_bad;
        r_last    <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_target_seat = r_target;
    assign o_granted     = r_granted;
    assign o_kind        = r_kind;
    assign o_bad_seat    = r_bad;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_excl_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eat & r_hun) == '0)
        else $error("seat both hungry and eating");

    a_release_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind && !r_bad && !r_last |=> r_valid && r_last && r_kind)
        else $error("left re-check not followed by right re-check");

    a_right_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_RIGHT |-> r_valid && !r_last && !r_bad)
        else $error("right re-check pending without left result");

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_bad |-> !r_granted && r_last)
        else $error("bad seat result granted or not last");
`endif

endmodule

// ----- hw/rtl/neighbor_exclusion_arbiter.sv -----
`timescale 1ns / 1ps
// Top level of the neighbor exclusion arbiter.
//
// Arbitrates a ring of seats where each seat shares a resource with both
// ring neighbors. A request (i_op, i_seat) is taken when start is high and
// busy is low. Acquire gives one result: granted or waiting. Release frees
// the seat and re-checks left then right neighbor: two results, the second
// with o_last set. A seat at or past the ring size gives one result with
// o_bad_seat set and leaves all state alone.
// Results come on o_valid for exactly one cycle; the receiver cannot stall.
// A request is written into the job queue; its first result comes from the
// back end result register. The back end runs one neighbor check per cycle;
// a release stays in BK_RIGHT for its right re-check before the next pop.
// A 2-deep job queue sits between intake and back end; busy is high while
// it is full. Ring size is written through i_cfg_valid/i_cfg_data
// (o_cfg_ready is always high); the user must write it only while idle,
// which the block does not enforce. Values are clamped to 2..MAX_SEATS.
// Reset: all seats thinking, ring size 5, queue empty, no result pending.
module neighbor_exclusion_arbiter import nea_pkg::*; #(
    parameter int MAX_SEATS = DEF_MAX_SEATS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_op,
    input  logic [SEAT_W-1:0] i_seat,
    input  logic              i_cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_cfg_ready,
    output logic              o_valid,
    output logic [SEAT_W-1:0] o_target_seat,
    output logic              o_granted,
    output logic              o_kind,
    output logic              o_bad_seat,
    output logic              o_last
);

    localparam int NW = $clog2(MAX_SEATS + 1);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    t_job          push_job;
    t_job          head_job;
    logic [NW-1:0] ring;

    nea_front #(
        .MAX_SEATS(MAX_SEATS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_op       (i_op),
        .i_seat     (i_seat),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job),
        .o_ring     (ring)
    );

    nea_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (head_job),
        .i_pop  (q_pop)
    );

    nea_back #(
        .MAX_SEATS(MAX_SEATS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_job        (head_job),
        .o_pop        (q_pop),
        .i_ring       (ring),
        .o_valid      (o_valid),
        .o_target_seat(o_target_seat),
        .o_granted    (o_granted),
        .o_kind       (o_kind),
        .o_bad_seat   (o_bad_seat),
        .o_last       (o_last)
    );

endmodule

// ----- bench/tb_neighbor_exclusion_arbiter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the neighbor exclusion arbiter with its own seat-ring predictor.
module tb_neighbor_exclusion_arbiter;
    import nea_pkg::*;

    localparam int RING_SLOTS = DEF_MAX_SEATS;
    localparam int SETTLE_CYC = 6;
    localparam int PHASE_LEN  = 150;

    typedef enum logic [1:0] {
        THINKING = 2'd0,
        HUNGRY   = 2'd1,
        EATING   = 2'd2
    } t_diner_state;

    typedef struct packed {
        logic              op;
        logic [SEAT_W-1:0] seat;
    } t_seat_request;

    typedef struct packed {
        logic [SEAT_W-1:0] target;
        logic              granted;
        logic              kind;
        logic              bad;
        logic              last;
    } t_seat_report;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_op        = OP_ACQUIRE;
    logic [SEAT_W-1:0] i_seat      = '0;
    logic              i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              busy;
    logic              o_cfg_ready;
    logic              o_valid;
    logic [SEAT_W-1:0] o_target_seat;
    logic              o_granted;
    logic              o_kind;
    logic              o_bad_seat;
    logic              o_last;

    t_seat_request pending_requests[$];
    t_seat_report  expected_reports[$];

    t_diner_state     ring_state[RING_SLOTS];
    logic [CFG_W-1:0] ring_cfg;

    int          sender_idle_pct = 0;
    int          errors          = 0;
    int          requests_taken  = 0;
    int          reports_seen    = 0;
    int          ring_writes     = 0;

    neighbor_exclusion_arbiter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_seat       (i_seat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_valid      (o_valid),
        .o_target_seat(o_target_seat),
        .o_granted    (o_granted),
        .o_kind       (o_kind),
        .o_bad_seat   (o_bad_seat),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[neighbor_exclusion_arbiter] ERROR");
        $finish;
    end

    // effective ring size: register clamped to 2..MAX_SEATS
    function automatic int unsigned ring_len(input logic [CFG_W-1:0] cfg);
        int unsigned n;
        n = 32'(cfg);
        if (n < RING_MIN) n = RING_MIN;
        if (n > RING_SLOTS) n = RING_SLOTS;
        return n;
    endfunction

    function automatic void try_feed(input int unsigned s, input int unsigned n);
        if (ring_state[(s + n - 1) % n] != EATING && ring_state[s] == HUNGRY &&
            ring_state[(s + 1) % n] != EATING)
            ring_state[s] = EATING;
    endfunction

    function automatic void arbitrate_request(input logic op, input logic [SEAT_W-1:0] s);
        int unsigned n;
        int unsigned si;
        int unsigned lft;
        int unsigned rgt;
        t_seat_report rep;
        n  = ring_len(ring_cfg);
        si = 32'(s);
        if (si >= n) begin
            rep = '{target: s, granted: 1'b0,
                    kind: (op == OP_RELEASE) ? KIND_RECHECK : KIND_REPLY,
                    bad: 1'b1, last: 1'b1};
            expected_reports.push_back(rep);
        end else if (op == OP_ACQUIRE) begin
            ring_state[si] = HUNGRY;
            try_feed(si, n);
            rep = '{target: s, granted: ring_state[si] == EATING, kind: KIND_REPLY,
                    bad: 1'b0, last: 1'b1};
            expected_reports.push_back(rep);
        end else begin
            ring_state[si] = THINKING;
            lft = (si + n - 1) % n;
            try_feed(lft, n);
            rep = '{target: SEAT_W'(lft), granted: ring_state[lft] == EATING,
                    kind: KIND_RECHECK, bad: 1'b0, last: 1'b0};
            expected_reports.push_back(rep);
            rgt = (si + 1) % n;
            try_feed(rgt, n);
            rep = '{target: SEAT_W'(rgt), granted: ring_state[rgt] == EATING,
                    kind: KIND_RECHECK, bad: 1'b0, last: 1'b1};
            expected_reports.push_back(rep);
        end
    endfunction

    function automatic void check_field(input string name, input logic [SEAT_W-1:0] want,
                                        input logic [SEAT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // request driver: holds start until the transfer, then loads the next request
    always @(posedge i_clk) begin
        t_seat_request req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = pending_requests.pop_front();
                start  <= 1'b1;
                i_op   <= req.op;
                i_seat <= req.seat;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and predictor update
    always @(posedge i_clk) begin
        t_seat_report want;
        if (!i_rst_n) begin
            ring_cfg = CFG_W'(RING_RESET);
            foreach (ring_state[k]) ring_state[k] = THINKING;
        end else begin
            if (o_valid) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual seat %0d", $time,
                             o_target_seat);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("target_seat", want.target, o_target_seat);
                    check_field("granted", SEAT_W'(want.granted), SEAT_W'(o_granted));
                    check_field("kind", SEAT_W'(want.kind), SEAT_W'(o_kind));
                    check_field("bad_seat", SEAT_W'(want.bad), SEAT_W'(o_bad_seat));
                    check_field("last", SEAT_W'(want.last), SEAT_W'(o_last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) ring_cfg = i_cfg_data;
            if (start && !busy) begin
                requests_taken++;
                arbitrate_request(i_op, i_seat);
            end
        end
    end

    task automatic queue_request(input logic op, input int unsigned s);
        t_seat_request req;
        req.op   = op;
        req.seat = SEAT_W'(s);
        pending_requests.push_back(req);
    endtask

    // wait until every request is taken and answered, then a short quiet stretch
    task automatic settle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || start || expected_reports.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_ring(input logic [CFG_W-1:0] value);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_writes++;
        @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] ring_plan[12];
        int unsigned n;
        ring_plan = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd0, 4'd6, 4'd9, 4'd7, 4'd2, 4'd4, 4'd12, 4'd5};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ring of five after reset: grants, waits, re-grant while eating, bad seats
        sender_idle_pct = 14;
        queue_request(OP_ACQUIRE, 0);
        queue_request(OP_ACQUIRE, 1);
        queue_request(OP_ACQUIRE, 4);
        queue_request(OP_RELEASE, 0);
        queue_request(OP_ACQUIRE, 1);
        queue_request(OP_RELEASE, 2);
        queue_request(OP_ACQUIRE, 3);
        queue_request(OP_ACQUIRE, 5);
        queue_request(OP_RELEASE, 7);
        queue_request(OP_RELEASE, 4);

        // two-seat ring: both re-checks land on the same neighbor
        write_ring(4'd2);
        queue_request(OP_ACQUIRE, 0);
        queue_request(OP_ACQUIRE, 1);
        queue_request(OP_RELEASE, 0);
        queue_request(OP_RELEASE, 1);
        queue_request(OP_ACQUIRE, 2);
        queue_request(OP_RELEASE, 3);

        // full ring, wrap at the top seat
        write_ring(4'd8);
        queue_request(OP_ACQUIRE, 7);
        queue_request(OP_ACQUIRE, 0);
        queue_request(OP_ACQUIRE, 6);
        queue_request(OP_RELEASE, 7);
        queue_request(OP_RELEASE, 0);

        foreach (ring_plan[ph]) begin
            write_ring(ring_plan[ph]);
            n = ring_len(ring_plan[ph]);
            case (ph % 3)
                0: sender_idle_pct = 14;
                1: sender_idle_pct = 81;
                default: sender_idle_pct = 0;
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (k == PHASE_LEN / 2 && ph % 4 == 0) settle();
                if ($urandom_range(9) == 0)
                    queue_request(1'($urandom_range(1)), $urandom_range(RING_SLOTS - 1));
                else
                    queue_request(1'($urandom_range(1)), $urandom_range(n - 1));
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        $display("Run covered %0d requests and %0d results over %0d ring size writes,",
                 requests_taken, reports_seen, ring_writes);
        $display("ring sizes from clamped low to clamped high, with light, heavy and no gaps.");
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("[neighbor_exclusion_arbiter] OK");
        end else begin
            $display("[neighbor_exclusion_arbiter] ERROR");
        end
        $finish;
    end

endmodule
